// ===== design/fltpm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fltpm_pkg: shared types and constants
// Types, constants and channel layout for the four-level page table manager.
// ----------------------------------------------------------------------------
package fltpm_pkg;

    localparam int TABLE_FRAMES_DEF = 16;
    localparam int ENTRIES          = 512;
    localparam int IDX_W            = 9;
    localparam int ENTRY_W          = 64;
    localparam int PAGE_SHIFT       = 12;
    localparam int VPAGE_W          = 36;
    localparam int PHYS_W           = 64;
    localparam int FLAGS_W          = 16;
    localparam int CMD_W            = 2;
    localparam int IN_DATA_W        = 120;
    localparam int OUT_DATA_W       = 8;

    localparam logic [PAGE_SHIFT-1:0] PTR_FLAGS     = 12'h003;
    localparam logic [ENTRY_W-1:0]    CLEAR_PRESENT = 64'hFFFF_FFFF_FFFF_FFFE;

    typedef enum logic [CMD_W-1:0] {
        CMD_MAP   = 2'd0,
        CMD_QUERY = 2'd1,
        CMD_UNMAP = 2'd2
    } cmd_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP,
        ST_WRITE,
        ST_FINISH
    } state_t;

    typedef struct packed {
        cmd_t                 cmd;
        logic [VPAGE_W-1:0]   vpage;
        logic [PHYS_W-1:0]    phys;
        logic [FLAGS_W-1:0]   flags;
    } walk_req_t;

    typedef struct packed {
        logic valid;
        logic is_mapped;
        logic out_of_tables;
    } walk_res_t;

endpackage

// ===== design/fltpm_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fltpm_ram: single-port synchronous RAM
// One read or write per cycle, read data registered.
// ----------------------------------------------------------------------------
module fltpm_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 8192
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/fltpm_walker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fltpm_walker: table walk sequencer
// Clears the table store after reset, then walks, creates and updates
// entries through the single store port, one level per cycle.
// ----------------------------------------------------------------------------
module fltpm_walker
    import fltpm_pkg::*;
#(
    parameter int TABLE_FRAMES = TABLE_FRAMES_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  walk_req_t                         in_req,
    output walk_res_t                         res,
    input  logic                              res_ready,
    output logic                              ram_en,
    output logic                              ram_we,
    output logic [$clog2(TABLE_FRAMES)+IDX_W-1:0] ram_addr,
    output logic [ENTRY_W-1:0]                ram_wdata,
    input  logic [ENTRY_W-1:0]                ram_rdata
);

    localparam int FRAME_W = $clog2(TABLE_FRAMES);
    localparam int ADDR_W  = FRAME_W + IDX_W;
    localparam int CNT_W   = $clog2(TABLE_FRAMES + 1);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(TABLE_FRAMES * ENTRIES - 1);
    localparam logic [CNT_W:0]    FRAME_LIMIT = (CNT_W + 1)'(TABLE_FRAMES);

    state_t             state_reg, state_next;
    logic [1:0]         level_reg, level_next;
    logic [FRAME_W-1:0] frame_reg, frame_next;
    logic [CNT_W-1:0]   free_reg, free_next;
    logic [ADDR_W-1:0]  clr_reg, clr_next;
    logic               mapped_reg, mapped_next;
    logic               oot_reg, oot_next;
    walk_req_t          req_reg;
    logic               ld_req;

    logic [FRAME_W-1:0] entry_frame;
    logic [IDX_W-1:0]   idx_cur, idx_nxt, idx_root;
    logic [CNT_W:0]     need_sum;
    logic [ENTRY_W-1:0] ptr_entry;
    logic               entry_absent;

    function automatic logic [IDX_W-1:0] level_idx(
        input logic [VPAGE_W-1:0] vp,
        input logic [1:0]         lvl
    );
        logic [IDX_W-1:0] r;
        unique case (lvl)
            2'd0:    r = vp[IDX_W-1:0];
            2'd1:    r = vp[2*IDX_W-1:IDX_W];
            2'd2:    r = vp[3*IDX_W-1:2*IDX_W];
            default: r = vp[4*IDX_W-1:3*IDX_W];
        endcase
        return r;
    endfunction

    assign entry_frame  = ram_rdata[PAGE_SHIFT +: FRAME_W];
    assign idx_cur      = level_idx(req_reg.vpage, level_reg);
    assign idx_nxt      = level_idx(req_reg.vpage, level_reg - 2'd1);
    assign idx_root     = level_idx(in_req.vpage, 2'd3);
    assign need_sum     = {1'b0, free_reg} + (CNT_W + 1)'(level_reg);
    assign ptr_entry    = {{(ENTRY_W - PAGE_SHIFT - FRAME_W){1'b0}},
                           free_reg[FRAME_W-1:0], PTR_FLAGS};
    assign entry_absent = (ram_rdata == '0) || !ram_rdata[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_CLEAR;
            level_reg  <= '0;
            frame_reg  <= '0;
            free_reg   <= CNT_W'(1);
            clr_reg    <= '0;
            mapped_reg <= 1'b0;
            oot_reg    <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            level_reg  <= level_next;
            frame_reg  <= frame_next;
            free_reg   <= free_next;
            clr_reg    <= clr_next;
            mapped_reg <= mapped_next;
            oot_reg    <= oot_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld_req)
        begin
            req_reg <= in_req;
        end
    end

    always_comb
    begin
        state_next        = state_reg;
        level_next        = level_reg;
        frame_next        = frame_reg;
        free_next         = free_reg;
        clr_next          = clr_reg;
        mapped_next       = mapped_reg;
        oot_next          = oot_reg;
        ld_req            = 1'b0;
        in_ready          = 1'b0;
        res.valid         = 1'b0;
        res.is_mapped     = mapped_reg;
        res.out_of_tables = oot_reg;
        ram_en            = 1'b0;
        ram_we            = 1'b0;
        ram_addr          = {frame_reg, idx_cur};
        ram_wdata         = '0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_en   = 1'b1;
                ram_we   = 1'b1;
                ram_addr = clr_reg;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == LAST_ADDR)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    ld_req      = 1'b1;
                    ram_en      = 1'b1;
                    ram_addr    = {{FRAME_W{1'b0}}, idx_root};
                    level_next  = 2'd3;
                    frame_next  = '0;
                    mapped_next = 1'b0;
                    oot_next    = 1'b0;
                    unique case (in_req.cmd)
                        CMD_MAP, CMD_QUERY, CMD_UNMAP: state_next = ST_LOOKUP;
                        default:                       state_next = ST_FINISH;
                    endcase
                end
            end
            ST_LOOKUP:
            begin
                unique case (req_reg.cmd)
                    CMD_MAP:
                    begin
                        if (ram_rdata == '0)
                        begin
                            if (need_sum > FRAME_LIMIT)
                            begin
                                oot_next   = 1'b1;
                                state_next = ST_FINISH;
                            end
                            else
                            begin
                                ram_en     = 1'b1;
                                ram_we     = 1'b1;
                                ram_wdata  = ptr_entry;
                                frame_next = free_reg[FRAME_W-1:0];
                                free_next  = free_reg + 1'b1;
                                level_next = level_reg - 2'd1;
                                state_next = ST_WRITE;
                            end
                        end
                        else
                        begin
                            frame_next = entry_frame;
                            level_next = level_reg - 2'd1;
                            if (level_reg == 2'd1)
                            begin
                                state_next = ST_WRITE;
                            end
                            else
                            begin
                                ram_en   = 1'b1;
                                ram_addr = {entry_frame, idx_nxt};
                            end
                        end
                    end
                    CMD_QUERY, CMD_UNMAP:
                    begin
                        if (entry_absent)
                        begin
                            state_next = ST_FINISH;
                        end
                        else if (level_reg == 2'd0)
                        begin
                            mapped_next = 1'b1;
                            state_next  = ST_FINISH;
                            if (req_reg.cmd == CMD_UNMAP)
                            begin
                                ram_en    = 1'b1;
                                ram_we    = 1'b1;
                                ram_wdata = ram_rdata & CLEAR_PRESENT;
                            end
                        end
                        else
                        begin
                            ram_en     = 1'b1;
                            ram_addr   = {entry_frame, idx_nxt};
                            frame_next = entry_frame;
                            level_next = level_reg - 2'd1;
                        end
                    end
                    default:
                    begin
                        state_next = ST_FINISH;
                    end
                endcase
            end
            ST_WRITE:
            begin
                ram_en = 1'b1;
                ram_we = 1'b1;
                if (level_reg == 2'd0)
                begin
                    ram_wdata  = req_reg.phys | ENTRY_W'(req_reg.flags);
                    state_next = ST_FINISH;
                end
                else
                begin
                    ram_wdata  = ptr_entry;
                    frame_next = free_reg[FRAME_W-1:0];
                    free_next  = free_reg + 1'b1;
                    level_next = level_reg - 2'd1;
                end
            end
            ST_FINISH:
            begin
                res.valid = 1'b1;
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
        endcase
    end

    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE || state_reg == ST_FINISH) |-> !ram_we)
        else $error("table store written outside a walk");

    a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
        free_reg <= CNT_W'(TABLE_FRAMES))
        else $error("frame allocator past the store");

    a_free_map_only: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LOOKUP && req_reg.cmd != CMD_MAP) |=> $stable(free_reg))
        else $error("frame allocated outside map");

    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> !(res.is_mapped && res.out_of_tables))
        else $error("result carries both flags");

endmodule

// ===== design/four_level_page_table_manager_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// four_level_page_table_manager_unit: four-level page table manager
// Maps, queries and unmaps pages in a radix page table held in on-chip RAM.
//
//   channel | dir | tuser        | tdata (low bit up)
//   s_*     | in  | command[1:0] | virt_page[35:0], phys_addr[63:0],
//           |     |              | leaf_flags[15:0], 4 zero bits
//   m_*     | out | -            | is_mapped, out_of_tables, 6 zero bits
//
// After reset the table store is cleared entry by entry, with s_tready low.
// A transaction walks the table levels in turn through the single store port
// (up to four levels), then hands the result to the output register and goes
// back to idle; a new request is accepted only in idle.
// The output register holds one result; a stalled m_tready holds the walker
// only once its next result is ready.
// ----------------------------------------------------------------------------
module four_level_page_table_manager_unit
    import fltpm_pkg::*;
#(
    parameter int TABLE_FRAMES = TABLE_FRAMES_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // virt_page, phys_addr, leaf_flags
    input  logic [CMD_W-1:0]      s_tuser,   // command
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata    // is_mapped, out_of_tables
);

    localparam int ADDR_W = $clog2(TABLE_FRAMES) + IDX_W;

    walk_req_t          req;
    walk_res_t          res;
    logic               res_ready;
    logic               ram_en, ram_we;
    logic [ADDR_W-1:0]  ram_addr;
    logic [ENTRY_W-1:0] ram_wdata, ram_rdata;

    logic               m_valid_reg, m_valid_next;
    logic [1:0]         m_flags_reg;

    assign req.cmd   = cmd_t'(s_tuser);
    assign req.vpage = s_tdata[VPAGE_W-1:0];
    assign req.phys  = s_tdata[VPAGE_W +: PHYS_W];
    assign req.flags = s_tdata[VPAGE_W + PHYS_W +: FLAGS_W];

    fltpm_walker #(
        .TABLE_FRAMES (TABLE_FRAMES)
    ) u_walker (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_req    (req),
        .res       (res),
        .res_ready (res_ready),
        .ram_en    (ram_en),
        .ram_we    (ram_we),
        .ram_addr  (ram_addr),
        .ram_wdata (ram_wdata),
        .ram_rdata (ram_rdata)
    );

    fltpm_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_FRAMES * ENTRIES)
    ) u_store (
        .clk   (clk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    assign res_ready = !m_valid_reg || m_tready;

    always_comb
    begin
        m_valid_next = m_valid_reg;
        if (res.valid && res_ready)
        begin
            m_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else
        begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res.valid && res_ready)
        begin
            m_flags_reg <= {res.out_of_tables, res.is_mapped};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(OUT_DATA_W - 2){1'b0}}, m_flags_reg};

endmodule
